### rtl/avkf_pkg.sv
// ----------------------------------------------------------------------------
// avkf_pkg
// Shared types, fixed-point helpers and the micro-program of the altitude and
// velocity Kalman filter.
// ----------------------------------------------------------------------------
package avkf_pkg;

    localparam int STATE_WIDTH = 48;
    localparam int STATE_FRAC  = 32;
    localparam int Q_SHIFT     = STATE_FRAC - 16;
    localparam int HALF_W      = (STATE_WIDTH + 1) / 2;
    localparam int MAG_W       = 2 * HALF_W;
    localparam int ACC_W       = 2 * MAG_W + 1;
    localparam int NUM_W       = STATE_WIDTH + STATE_FRAC;
    localparam int CNT_W       = $clog2(NUM_W + 1);
    localparam int FX_W        = 33 + Q_SHIFT + STATE_WIDTH;
    localparam int PC_W        = 6;

    typedef logic signed [STATE_WIDTH-1:0] fx_t;

    localparam fx_t MAX_FX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam fx_t MIN_FX = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic               action;
        logic signed [31:0] altitude_meas;
    } in_t;

    typedef struct packed {
        logic signed [31:0] est_altitude;
        logic signed [31:0] est_velocity;
    } out_t;

    typedef struct packed {
        logic [16:0] step_period;
        logic [26:0] meas_noise;
        logic [26:0] accel_noise;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_HALF,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [5:0] {
        SRC_ZERO, SRC_ONE, SRC_TS, SRC_Q, SRC_RN, SRC_Z,
        SRC_SQ, SRC_G0, SRC_QG0, SRC_QG1,
        SRC_T0, SRC_T2, SRC_T3,
        SRC_XPR0, SRC_XPR1, SRC_XPO0, SRC_XPO1,
        SRC_PPR0, SRC_PPR1, SRC_PPR2, SRC_PPR3,
        SRC_PPO0, SRC_PPO1, SRC_PPO2, SRC_PPO3,
        SRC_K0, SRC_K1, SRC_INN, SRC_A, SRC_C, SRC_DEN
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
        logic last;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
        src_t a;
        src_t b;
        src_t dst;
        logic load_in;
        logic load_out;
        logic out_post;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;

    localparam logic [PC_W-1:0] PRED_START = PC_W'(0);
    localparam logic [PC_W-1:0] UPD_START  = PC_W'(25);

    // Q16.16 (33-bit signed) to state format, saturated
    function automatic fx_t from_q16(input logic signed [32:0] v);
        logic signed [FX_W-1:0] w;
        w = FX_W'(v) <<< Q_SHIFT;
        if (w > FX_W'(MAX_FX)) return MAX_FX;
        if (w < FX_W'(MIN_FX)) return MIN_FX;
        return w[STATE_WIDTH-1:0];
    endfunction

    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic signed [STATE_WIDTH:0] s;
        s = {a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b};
        if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) return s[STATE_WIDTH] ? MIN_FX : MAX_FX;
        return s[STATE_WIDTH-1:0];
    endfunction

    function automatic fx_t sat_sub(input fx_t a, input fx_t b);
        logic signed [STATE_WIDTH:0] s;
        s = {a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b};
        if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) return s[STATE_WIDTH] ? MIN_FX : MAX_FX;
        return s[STATE_WIDTH-1:0];
    endfunction

    localparam fx_t ONE_FX = from_q16(33'sd65536);

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b,
                                input src_t dst, input logic last);
        uop_t u;
        u.op   = op;
        u.a    = a;
        u.b    = b;
        u.dst  = dst;
        u.last = last;
        return u;
    endfunction

    // predict program from PRED_START, update program from UPD_START
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        case (pc)
            6'd0:  return mk(OP_MUL,  SRC_TS,   SRC_TS,   SRC_SQ,   1'b0);
            6'd1:  return mk(OP_HALF, SRC_SQ,   SRC_ZERO, SRC_G0,   1'b0);
            6'd2:  return mk(OP_MUL,  SRC_G0,   SRC_Q,    SRC_QG0,  1'b0);
            6'd3:  return mk(OP_MUL,  SRC_TS,   SRC_Q,    SRC_QG1,  1'b0);
            6'd4:  return mk(OP_MUL,  SRC_TS,   SRC_XPO1, SRC_T0,   1'b0);
            6'd5:  return mk(OP_ADD,  SRC_XPO0, SRC_T0,   SRC_XPR0, 1'b0);
            6'd6:  return mk(OP_ADD,  SRC_XPO1, SRC_ZERO, SRC_XPR1, 1'b0);
            6'd7:  return mk(OP_MUL,  SRC_PPO1, SRC_TS,   SRC_T0,   1'b0);
            6'd8:  return mk(OP_ADD,  SRC_PPO0, SRC_T0,   SRC_T2,   1'b0);
            6'd9:  return mk(OP_MUL,  SRC_PPO3, SRC_TS,   SRC_T0,   1'b0);
            6'd10: return mk(OP_ADD,  SRC_PPO2, SRC_T0,   SRC_T3,   1'b0);
            6'd11: return mk(OP_MUL,  SRC_TS,   SRC_T3,   SRC_T0,   1'b0);
            6'd12: return mk(OP_ADD,  SRC_T2,   SRC_T0,   SRC_PPR0, 1'b0);
            6'd13: return mk(OP_MUL,  SRC_TS,   SRC_PPO3, SRC_T0,   1'b0);
            6'd14: return mk(OP_ADD,  SRC_PPO1, SRC_T0,   SRC_PPR1, 1'b0);
            6'd15: return mk(OP_ADD,  SRC_T3,   SRC_ZERO, SRC_PPR2, 1'b0);
            6'd16: return mk(OP_ADD,  SRC_PPO3, SRC_ZERO, SRC_PPR3, 1'b0);
            6'd17: return mk(OP_MUL,  SRC_G0,   SRC_QG0,  SRC_T0,   1'b0);
            6'd18: return mk(OP_ADD,  SRC_PPR0, SRC_T0,   SRC_PPR0, 1'b0);
            6'd19: return mk(OP_MUL,  SRC_G0,   SRC_QG1,  SRC_T0,   1'b0);
            6'd20: return mk(OP_ADD,  SRC_PPR1, SRC_T0,   SRC_PPR1, 1'b0);
            6'd21: return mk(OP_MUL,  SRC_TS,   SRC_QG0,  SRC_T0,   1'b0);
            6'd22: return mk(OP_ADD,  SRC_PPR2, SRC_T0,   SRC_PPR2, 1'b0);
            6'd23: return mk(OP_MUL,  SRC_TS,   SRC_QG1,  SRC_T0,   1'b0);
            6'd24: return mk(OP_ADD,  SRC_PPR3, SRC_T0,   SRC_PPR3, 1'b1);
            6'd25: return mk(OP_ADD,  SRC_PPR0, SRC_RN,   SRC_DEN,  1'b0);
            6'd26: return mk(OP_DIV,  SRC_PPR0, SRC_DEN,  SRC_K0,   1'b0);
            6'd27: return mk(OP_DIV,  SRC_PPR2, SRC_DEN,  SRC_K1,   1'b0);
            6'd28: return mk(OP_SUB,  SRC_Z,    SRC_XPR0, SRC_INN,  1'b0);
            6'd29: return mk(OP_MUL,  SRC_K0,   SRC_INN,  SRC_T0,   1'b0);
            6'd30: return mk(OP_ADD,  SRC_XPR0, SRC_T0,   SRC_XPO0, 1'b0);
            6'd31: return mk(OP_MUL,  SRC_K1,   SRC_INN,  SRC_T0,   1'b0);
            6'd32: return mk(OP_ADD,  SRC_XPR1, SRC_T0,   SRC_XPO1, 1'b0);
            6'd33: return mk(OP_SUB,  SRC_ONE,  SRC_K0,   SRC_A,    1'b0);
            6'd34: return mk(OP_SUB,  SRC_ZERO, SRC_K1,   SRC_C,    1'b0);
            6'd35: return mk(OP_MUL,  SRC_A,    SRC_PPR0, SRC_PPO0, 1'b0);
            6'd36: return mk(OP_MUL,  SRC_A,    SRC_PPR1, SRC_PPO1, 1'b0);
            6'd37: return mk(OP_MUL,  SRC_C,    SRC_PPR0, SRC_T0,   1'b0);
            6'd38: return mk(OP_ADD,  SRC_T0,   SRC_PPR2, SRC_PPO2, 1'b0);
            6'd39: return mk(OP_MUL,  SRC_C,    SRC_PPR1, SRC_T0,   1'b0);
            6'd40: return mk(OP_ADD,  SRC_T0,   SRC_PPR3, SRC_PPO3, 1'b1);
            default: return mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b1);
        endcase
    endfunction

endpackage

### rtl/avkf_ctrl.sv
// ----------------------------------------------------------------------------
// avkf_ctrl
// Sequencer: steps the datapath through the predict or update micro-program
// and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module avkf_ctrl
    import avkf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_action,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              post_reg, post_next;
    logic              m_valid_reg, m_valid_next;
    uop_t              uop;

    assign uop     = uop_rom(pc_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        post_next    = post_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd          = '0;
        cmd.op       = uop.op;
        cmd.a        = uop.a;
        cmd.b        = uop.b;
        cmd.dst      = uop.dst;
        cmd.out_post = post_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    post_next   = s_action;
                    pc_next     = s_action ? UPD_START : PRED_START;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.done) begin
                    if (uop.last) begin
                        state_next = ST_DONE;
                    end else begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= PRED_START;
            post_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            post_reg    <= post_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/avkf_dp.sv
// ----------------------------------------------------------------------------
// avkf_dp
// Datapath: filter state, saturating adder, multi-cycle multiplier built from
// four half-width partial products, and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
module avkf_dp
    import avkf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t cmd,
    output sts_t sts,
    input  cfg_t cfg,
    input  in_t  s_data,
    output out_t m_data
);

    localparam int SM_W = ACC_W + NUM_W;

    // filter state
    fx_t xpr0_reg, xpr1_reg, xpo0_reg, xpo1_reg;
    fx_t ppr0_reg, ppr1_reg, ppr2_reg, ppr3_reg;
    fx_t ppo0_reg, ppo1_reg, ppo2_reg, ppo3_reg;
    // scratch
    fx_t sq_reg, g0_reg, qg0_reg, qg1_reg, t0_reg, t2_reg, t3_reg;
    fx_t k0_reg, k1_reg, inn_reg, a_reg, c_reg, den_reg;
    logic signed [31:0] meas_reg;
    out_t out_reg;

    // execution unit
    logic             busy_reg;
    op_t              op_reg;
    src_t             dst_reg;
    fx_t              opa_reg, opb_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] ma_reg, mb_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [STATE_WIDTH:0]   rem_reg;
    logic [NUM_W-1:0]       num_reg, quo_reg;
    logic [STATE_WIDTH-1:0] dvs_reg;
    logic             dzero_reg;

    fx_t              opa, opb, result;
    logic             done;
    logic [HALF_W-1:0] pa, pb;
    logic [MAG_W-1:0] pp;
    logic [ACC_W-1:0] pp_sh, rnd;
    logic [STATE_WIDTH:0] rem_sh;
    logic             ge, rbit;
    logic [NUM_W:0]   qr;

    function automatic fx_t src_val(input src_t s);
        case (s)
            SRC_ZERO: return '0;
            SRC_ONE:  return ONE_FX;
            SRC_TS:   return from_q16(33'(cfg.step_period));
            SRC_Q:    return from_q16(33'(cfg.accel_noise));
            SRC_RN:   return from_q16(33'(cfg.meas_noise));
            SRC_Z:    return from_q16({meas_reg[31], meas_reg});
            SRC_SQ:   return sq_reg;
            SRC_G0:   return g0_reg;
            SRC_QG0:  return qg0_reg;
            SRC_QG1:  return qg1_reg;
            SRC_T0:   return t0_reg;
            SRC_T2:   return t2_reg;
            SRC_T3:   return t3_reg;
            SRC_XPR0: return xpr0_reg;
            SRC_XPR1: return xpr1_reg;
            SRC_XPO0: return xpo0_reg;
            SRC_XPO1: return xpo1_reg;
            SRC_PPR0: return ppr0_reg;
            SRC_PPR1: return ppr1_reg;
            SRC_PPR2: return ppr2_reg;
            SRC_PPR3: return ppr3_reg;
            SRC_PPO0: return ppo0_reg;
            SRC_PPO1: return ppo1_reg;
            SRC_PPO2: return ppo2_reg;
            SRC_PPO3: return ppo3_reg;
            SRC_K0:   return k0_reg;
            SRC_K1:   return k1_reg;
            SRC_INN:  return inn_reg;
            SRC_A:    return a_reg;
            SRC_C:    return c_reg;
            SRC_DEN:  return den_reg;
            default:  return '0;
        endcase
    endfunction

    function automatic logic [STATE_WIDTH-1:0] mag(input fx_t v);
        return v[STATE_WIDTH-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic fx_t sat_mag(input logic neg, input logic [SM_W-1:0] m);
        if (m > SM_W'($unsigned(MAX_FX))) return neg ? MIN_FX : MAX_FX;
        return neg ? -$signed(m[STATE_WIDTH-1:0]) : $signed(m[STATE_WIDTH-1:0]);
    endfunction

    // round on magnitude to Q16.16, saturate to 32 bits
    function automatic logic [31:0] to_q16(input fx_t v);
        logic [STATE_WIDTH:0] m;
        m = ((STATE_WIDTH+1)'(mag(v)) + (((STATE_WIDTH+1)'(1) << Q_SHIFT) >> 1)) >> Q_SHIFT;
        if (!v[STATE_WIDTH-1])
            return (m > (STATE_WIDTH+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
        return (m >= (STATE_WIDTH+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : -m[31:0];
    endfunction

    assign opa = src_val(cmd.a);
    assign opb = src_val(cmd.b);

    // partial product for the current quarter
    assign pa = cnt_reg[1] ? ma_reg[MAG_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign pb = cnt_reg[0] ? mb_reg[MAG_W-1:HALF_W] : mb_reg[HALF_W-1:0];
    assign pp = MAG_W'(pa) * MAG_W'(pb);

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    pp_sh = ACC_W'(pp);
            2'd3:    pp_sh = ACC_W'(pp) << MAG_W;
            default: pp_sh = ACC_W'(pp) << HALF_W;
        endcase
    end

    assign rnd    = acc_reg + ((ACC_W'(1) << STATE_FRAC) >> 1);
    assign rem_sh = {rem_reg[STATE_WIDTH-1:0], num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign rbit   = {rem_reg, 1'b0} >= (STATE_WIDTH+2)'(dvs_reg);
    assign qr     = (NUM_W+1)'(quo_reg) + (NUM_W+1)'(rbit);

    always_comb begin
        done   = 1'b0;
        result = '0;
        case (op_reg)
            OP_ADD: begin
                done   = busy_reg;
                result = sat_add(opa_reg, opb_reg);
            end
            OP_SUB: begin
                done   = busy_reg;
                result = sat_sub(opa_reg, opb_reg);
            end
            OP_HALF: begin
                done   = busy_reg;
                result = (opa_reg >>> 1) + STATE_WIDTH'(opa_reg[0]);
            end
            OP_MUL: begin
                done   = busy_reg && (cnt_reg == CNT_W'(4));
                result = sat_mag(neg_reg, SM_W'(rnd >> STATE_FRAC));
            end
            OP_DIV: begin
                done   = busy_reg && (cnt_reg == CNT_W'(NUM_W));
                result = dzero_reg ? '0 : sat_mag(neg_reg, SM_W'(qr));
            end
            default: begin
                done   = busy_reg;
                result = '0;
            end
        endcase
    end

    assign sts.done = done;
    assign m_data   = out_reg;

    // execution unit control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg    <= cmd.op;
            dst_reg   <= cmd.dst;
            opa_reg   <= opa;
            opb_reg   <= opb;
            cnt_reg   <= '0;
            ma_reg    <= MAG_W'(mag(opa));
            mb_reg    <= MAG_W'(mag(opb));
            acc_reg   <= '0;
            neg_reg   <= (cmd.op == OP_DIV) ? opa[STATE_WIDTH-1]
                                            : (opa[STATE_WIDTH-1] ^ opb[STATE_WIDTH-1]);
            num_reg   <= NUM_W'(mag(opa)) << STATE_FRAC;
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= $unsigned(opb);
            dzero_reg <= opb[STATE_WIDTH-1] || (opb == '0);
        end else if (busy_reg && !done) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (op_reg == OP_MUL) begin
                acc_reg <= acc_reg + pp_sh;
            end
            if (op_reg == OP_DIV) begin
                rem_reg <= ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                num_reg <= num_reg << 1;
            end
        end
    end

    // filter state with its reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xpr0_reg <= '0;
            xpr1_reg <= '0;
            xpo0_reg <= '0;
            xpo1_reg <= '0;
            ppr0_reg <= ONE_FX;
            ppr1_reg <= '0;
            ppr2_reg <= '0;
            ppr3_reg <= ONE_FX;
            ppo0_reg <= ONE_FX;
            ppo1_reg <= '0;
            ppo2_reg <= '0;
            ppo3_reg <= ONE_FX;
        end else if (done) begin
            case (dst_reg)
                SRC_XPR0: xpr0_reg <= result;
                SRC_XPR1: xpr1_reg <= result;
                SRC_XPO0: xpo0_reg <= result;
                SRC_XPO1: xpo1_reg <= result;
                SRC_PPR0: ppr0_reg <= result;
                SRC_PPR1: ppr1_reg <= result;
                SRC_PPR2: ppr2_reg <= result;
                SRC_PPR3: ppr3_reg <= result;
                SRC_PPO0: ppo0_reg <= result;
                SRC_PPO1: ppo1_reg <= result;
                SRC_PPO2: ppo2_reg <= result;
                SRC_PPO3: ppo3_reg <= result;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            case (dst_reg)
                SRC_SQ:  sq_reg  <= result;
                SRC_G0:  g0_reg  <= result;
                SRC_QG0: qg0_reg <= result;
                SRC_QG1: qg1_reg <= result;
                SRC_T0:  t0_reg  <= result;
                SRC_T2:  t2_reg  <= result;
                SRC_T3:  t3_reg  <= result;
                SRC_K0:  k0_reg  <= result;
                SRC_K1:  k1_reg  <= result;
                SRC_INN: inn_reg <= result;
                SRC_A:   a_reg   <= result;
                SRC_C:   c_reg   <= result;
                SRC_DEN: den_reg <= result;
                default: ;
            endcase
        end
        if (cmd.load_in) begin
            meas_reg <= s_data.altitude_meas;
        end
        if (cmd.load_out) begin
            out_reg.est_altitude <= to_q16(cmd.out_post ? xpo0_reg : xpr0_reg);
            out_reg.est_velocity <= to_q16(cmd.out_post ? xpo1_reg : xpr1_reg);
        end
    end

endmodule

### rtl/altitude_velocity_kalman_filter.sv
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter
// Two-state constant-velocity Kalman filter with APB configuration registers.
// ----------------------------------------------------------------------------
// Micro-programs: predict runs 12 multiplies, 12 adds and one halving; update
// runs two divides, 6 multiplies and 8 adds or subtracts; each ends with one
// result load before m_valid. One item at a time; the next item is taken while
// the result waits. A single shared unit does every add, multiply and divide.
// Reset (aresetn low, synchronous): state zero, covariances identity,
// registers to 655, 5.0, 5.0.
module altitude_velocity_kalman_filter
    import avkf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_STEP_PERIOD = 2'd0;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_ACCEL_NOISE = 2'd2;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_period <= 17'd655;
            cfg_reg.meas_noise  <= 27'd327680;
            cfg_reg.accel_noise <= 27'd327680;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_STEP_PERIOD: cfg_reg.step_period <= pwdata[16:0];
                REG_MEAS_NOISE:  cfg_reg.meas_noise  <= pwdata[26:0];
                REG_ACCEL_NOISE: cfg_reg.accel_noise <= pwdata[26:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STEP_PERIOD: prdata = 32'(cfg_reg.step_period);
            REG_MEAS_NOISE:  prdata = 32'(cfg_reg.meas_noise);
            REG_ACCEL_NOISE: prdata = 32'(cfg_reg.accel_noise);
            default:         prdata = '0;
        endcase
    end

    avkf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    avkf_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
